/* design/bitmap_page_allocator_unit_assert.svh */
// Assertion macros for the bitmap page allocator checker.
`ifndef BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPA_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bitmap page allocator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bitmap page allocator: next-cycle check failed");

`endif

/* design/bpa_pkg.sv */
// Shared constants and types of the bitmap page allocator.
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;
   localparam int MAX_PAGES     = 65536;
   localparam int MAP_WORD_BITS = 64;
   localparam int MAP_WORDS     = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int ADDR_W        = $clog2(MAP_WORDS);
   localparam int BIT_W         = $clog2(MAP_WORD_BITS);
   localparam int IDX_W         = $clog2(MAX_PAGES);
   localparam int CNT_W         = 17;
   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic                     wr_en;
      logic [ADDR_W-1:0]        wr_addr;
      logic [MAP_WORD_BITS-1:0] wr_data;
      logic                     rd_en;
      logic [ADDR_W-1:0]        rd_addr;
   } ram_req_type;
endpackage
`default_nettype wire

/* design/bpa_if.sv */
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
`default_nettype none
interface bpa_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [16:0] page_count;
   logic [15:0] first_page;
   modport source (output valid, command, page_count, first_page, input ready);
   modport sink   (input valid, command, page_count, first_page, output ready);
endinterface

interface bpa_rsp_if;
   logic        valid;
   logic        ready;
   logic        success;
   logic [15:0] run_start;
   logic [16:0] free_count;
   modport source (output valid, success, run_start, free_count, input ready);
   modport sink   (input valid, success, run_start, free_count, output ready);
endinterface
`default_nettype wire

/* design/bpa_map_store.sv */
// Used-page map memory with its sweep after reset that marks every page used.
`timescale 1ns / 1ps
`default_nettype none
module bpa_map_store (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire bpa_pkg::ram_req_type                 ram_req,
   output logic [bpa_pkg::MAP_WORD_BITS-1:0]         rd_data,
   output logic                                      busy
);
   logic [bpa_pkg::MAP_WORD_BITS-1:0] mem [bpa_pkg::MAP_WORDS];
   logic [bpa_pkg::ADDR_W:0]          clr_cnt_ff;
   logic [bpa_pkg::MAP_WORD_BITS-1:0] rd_data_ff;

   // The sweep is finished once the counter reaches the word count.
   assign busy    = ~clr_cnt_ff[bpa_pkg::ADDR_W];
   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (busy) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         mem[clr_cnt_ff[bpa_pkg::ADDR_W-1:0]] <= {bpa_pkg::MAP_WORD_BITS{1'b1}};
      end else if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end
endmodule
`default_nettype wire

/* design/bitmap_page_allocator_unit.sv */
// An allocate scans pages, then marks the pages of the run that it found, and fetches
// each map word that it needs; a free walks every page in its range and fetches each
// word. One transaction is in flight at a time; the walk over the map, one page a
// cycle except while a map word is being fetched, sets the rate.
// After reset the map is swept to all used, during which no
// request is accepted.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_allocator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   bpa_req_if.sink          req_if,
   bpa_rsp_if.source        rsp_if,
   input  wire logic        csr_write_en,
   input  wire logic [16:0] csr_write_data
);
   typedef enum logic [2:0] {ST_IDLE, ST_STEP, ST_LOAD, ST_FETCH, ST_RESP} state_type;
   typedef enum logic [1:0] {PH_ALLOC1, PH_ALLOC2, PH_MARK, PH_FREE} phase_type;

   localparam logic [bpa_pkg::CNT_W-1:0] EFF_MAX = bpa_pkg::CNT_W'(bpa_pkg::MAX_PAGES);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [bpa_pkg::CNT_W-1:0] cur_ff, cur_in, limit_ff, limit_in, run_ff, run_in;
   logic [bpa_pkg::CNT_W-1:0] count_ff, count_in, cursor_ff, cursor_in;
   logic [bpa_pkg::CNT_W-1:0] free_ff, free_in, total_ff, total_in;
   logic [bpa_pkg::IDX_W-1:0] start_ff, start_in;
   logic [bpa_pkg::MAP_WORD_BITS-1:0] word_ff, word_in;
   logic [bpa_pkg::ADDR_W-1:0] tag_ff, tag_in;
   logic tag_valid_ff, tag_valid_in, dirty_ff, dirty_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_success_ff, rsp_success_in;
   logic [bpa_pkg::IDX_W-1:0] rsp_start_ff, rsp_start_in;
   logic [bpa_pkg::CNT_W-1:0] rsp_free_ff, rsp_free_in;

   bpa_pkg::ram_req_type ram_req;
   logic [bpa_pkg::MAP_WORD_BITS-1:0] rd_data;
   logic store_busy;

   logic [bpa_pkg::CNT_W-1:0] eff_total, lim2, cur_next;
   logic [bpa_pkg::CNT_W:0]   free_end;
   logic [bpa_pkg::ADDR_W-1:0] cur_word;
   logic [bpa_pkg::BIT_W-1:0]  cur_bit;
   logic hit_word, bit_now;

   bpa_map_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (rd_data),
      .busy    (store_busy)
   );

   assign eff_total = (total_ff > EFF_MAX) ? EFF_MAX : total_ff;
   assign lim2      = (cursor_ff < eff_total) ? cursor_ff : eff_total;
   assign free_end  = {2'b00, req_if.first_page} + {1'b0, req_if.page_count};
   assign cur_word  = cur_ff[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W];
   assign cur_bit   = cur_ff[bpa_pkg::BIT_W-1:0];
   assign hit_word  = tag_valid_ff && (tag_ff == cur_word);
   assign bit_now   = word_ff[cur_bit];
   assign cur_next  = cur_ff + 1'b1;

   assign req_if.ready      = (state_ff == ST_IDLE) && !store_busy;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.success    = rsp_success_ff;
   assign rsp_if.run_start  = rsp_start_ff;
   assign rsp_if.free_count = rsp_free_ff;

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      cur_in         = cur_ff;
      limit_in       = limit_ff;
      run_in         = run_ff;
      count_in       = count_ff;
      cursor_in      = cursor_ff;
      free_in        = free_ff;
      total_in       = csr_write_en ? csr_write_data : total_ff;
      start_in       = start_ff;
      word_in        = word_ff;
      tag_in         = tag_ff;
      tag_valid_in   = tag_valid_ff;
      dirty_in       = dirty_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_success_in = rsp_success_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_free_in    = rsp_free_ff;
      ram_req         = '0;
      ram_req.wr_addr = tag_ff;
      ram_req.wr_data = word_ff;
      ram_req.rd_addr = cur_word;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid && req_if.ready) begin
               tag_valid_in = 1'b0;
               dirty_in     = 1'b0;
               run_in       = '0;
               count_in     = req_if.page_count;
               if (req_if.command == bpa_pkg::CMD_FREE) begin
                  phase_in = PH_FREE;
                  cur_in   = {1'b0, req_if.first_page};
                  limit_in = (free_end > {1'b0, eff_total}) ? eff_total
                                                           : free_end[bpa_pkg::CNT_W-1:0];
                  state_in = ST_STEP;
               end else if (req_if.page_count == '0) begin
                  // A zero-length allocation fails at once and changes nothing.
                  rsp_valid_in   = 1'b1;
                  rsp_success_in = 1'b0;
                  rsp_start_in   = '0;
                  rsp_free_in    = free_ff;
                  state_in       = ST_RESP;
               end else begin
                  phase_in = PH_ALLOC1;
                  cur_in   = cursor_ff;
                  limit_in = eff_total;
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            if (cur_ff >= limit_ff) begin
               unique case (phase_ff)
                  PH_ALLOC1: begin
                     phase_in = PH_ALLOC2;
                     cur_in   = '0;
                     run_in   = '0;
                     limit_in = lim2;
                  end
                  PH_ALLOC2: begin
                     cursor_in      = limit_ff;
                     rsp_success_in = 1'b0;
                     rsp_start_in   = '0;
                     rsp_free_in    = free_ff;
                  end
                  PH_MARK: begin
                     cursor_in      = limit_ff;
                     free_in        = (free_ff >= count_ff) ? free_ff - count_ff : '0;
                     rsp_success_in = 1'b1;
                     rsp_start_in   = start_ff;
                     rsp_free_in    = (free_ff >= count_ff) ? free_ff - count_ff : '0;
                  end
                  PH_FREE: begin
                     rsp_success_in = 1'b1;
                     rsp_start_in   = '0;
                     rsp_free_in    = free_ff;
                  end
                  default: ;
               endcase
               if (phase_ff != PH_ALLOC1) begin
                  ram_req.wr_en = dirty_ff;
                  dirty_in      = 1'b0;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_RESP;
               end
            end else if (!hit_word) begin
               // Write the cached word back before fetching the one under the cursor.
               ram_req.wr_en = dirty_ff;
               dirty_in      = 1'b0;
               state_in      = ST_LOAD;
            end else begin
               cur_in = cur_next;
               unique case (phase_ff)
                  PH_ALLOC1, PH_ALLOC2: begin
                     if (bit_now) begin
                        run_in = '0;
                     end else if (run_ff + 1'b1 == count_ff) begin
                        start_in = bpa_pkg::IDX_W'(cur_next - count_ff);
                        cur_in   = cur_next - count_ff;
                        limit_in = cur_next;
                        phase_in = PH_MARK;
                     end else begin
                        run_in = run_ff + 1'b1;
                     end
                  end
                  PH_MARK: begin
                     word_in[cur_bit] = 1'b1;
                     dirty_in         = 1'b1;
                  end
                  PH_FREE: begin
                     if (bit_now) begin
                        word_in[cur_bit] = 1'b0;
                        dirty_in         = 1'b1;
                        if (free_ff < bpa_pkg::COUNT_MAX) begin
                           free_in = free_ff + 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD: begin
            ram_req.rd_en = 1'b1;
            state_in      = ST_FETCH;
         end
         ST_FETCH: begin
            word_in      = rd_data;
            tag_in       = cur_word;
            tag_valid_in = 1'b1;
            state_in     = ST_STEP;
         end
         ST_RESP: begin
            if (rsp_if.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_ALLOC1;
         cursor_ff    <= '0;
         free_ff      <= '0;
         total_ff     <= '0;
         tag_valid_ff <= 1'b0;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cursor_ff    <= cursor_in;
         free_ff      <= free_in;
         total_ff     <= total_in;
         tag_valid_ff <= tag_valid_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff         <= cur_in;
      limit_ff       <= limit_in;
      run_ff         <= run_in;
      count_ff       <= count_in;
      start_ff       <= start_in;
      word_ff        <= word_in;
      tag_ff         <= tag_in;
      rsp_success_ff <= rsp_success_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_free_ff    <= rsp_free_in;
   end
endmodule
`default_nettype wire

/* design/bpa_checker.sv */
// Port-level checks for the bitmap page allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_page_allocator_unit_assert.svh"
module bpa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_success,
   input wire logic [15:0] rsp_run_start,
   input wire logic [16:0] rsp_free_count
);
   `BPA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `BPA_ASSERT_SAME(a_no_accept_with_pending, rsp_valid, !req_ready)
   `BPA_ASSERT_SAME(a_fail_start_zero, rsp_valid && !rsp_success, rsp_run_start == 16'd0)
   `BPA_ASSERT_SAME(a_count_bound, rsp_valid, rsp_free_count <= 17'd65536)
   `BPA_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind bitmap_page_allocator_unit bpa_checker u_bpa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_success    (rsp_if.success),
   .rsp_run_start  (rsp_if.run_start),
   .rsp_free_count (rsp_if.free_count)
);
`default_nettype wire

/* test/bitmap_page_allocator_unit_tb.sv */
// Self-checking testbench for the bitmap page allocator: directed table, then random traffic.
`timescale 1ns / 1ps
module bitmap_page_allocator_unit_tb;

   typedef struct {
      logic        success;
      logic [15:0] run_start;
      logic [16:0] free_count;
   } page_grant_type;

   typedef struct {
      bit          is_cfg;
      logic [16:0] cfg_total;
      logic        command;
      logic [16:0] page_count;
      logic [15:0] first_page;
      bit          typed;
      logic        success;
      logic [15:0] run_start;
      logic [16:0] free_count;
   } dir_row_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [16:0] csr_write_data;

   bpa_req_if req_bus ();
   bpa_rsp_if rsp_bus ();

   bitmap_page_allocator_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_bus),
      .rsp_if         (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Shadow copy of the allocator state.
   bit          page_busy [0:bpa_pkg::MAX_PAGES-1];
   int unsigned cursor_shadow;
   int unsigned free_shadow;
   int unsigned total_shadow;

   page_grant_type expected_grants[$];
   int          mismatch_count = 0;
   bit          quiet_phase = 0;
   bit          long_hold_req = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int unsigned window_size();
      return (total_shadow < bpa_pkg::MAX_PAGES) ? total_shadow : bpa_pkg::MAX_PAGES;
   endfunction

   // Next-fit search from the cursor up to lim; marks the run used on a hit.
   function automatic bit find_run(int unsigned count, int unsigned lim,
                                   output int unsigned start);
      int unsigned run;
      int unsigned p;
      run = 0;
      start = 0;
      while (cursor_shadow < lim) begin
         p = cursor_shadow;
         cursor_shadow++;
         if (!page_busy[p]) begin
            run++;
            if (run == count) begin
               start = cursor_shadow - count;
               for (int unsigned i = start; i < cursor_shadow; i++) page_busy[i] = 1'b1;
               return 1'b1;
            end
         end else begin
            run = 0;
         end
      end
      return 1'b0;
   endfunction

   function automatic page_grant_type predict_page_op(logic command, int unsigned count,
                                                      int unsigned first);
      page_grant_type g;
      int unsigned win;
      int unsigned old_cursor;
      int unsigned start;
      int unsigned stop;
      bit hit;
      win = window_size();
      g.success = 1'b0;
      g.run_start = '0;
      start = 0;
      if (command == bpa_pkg::CMD_ALLOC) begin
         if (count != 0) begin
            old_cursor = cursor_shadow;
            hit = 1'b0;
            if (cursor_shadow < win) hit = find_run(count, win, start);
            if (!hit) begin
               cursor_shadow = 0;
               hit = find_run(count, (old_cursor < win) ? old_cursor : win, start);
            end
            if (hit) begin
               g.success = 1'b1;
               g.run_start = start[15:0];
               free_shadow = (free_shadow >= count) ? free_shadow - count : 0;
            end
         end
      end else begin
         stop = first + count;
         if (stop > win) stop = win;
         for (int unsigned i = first; i < stop; i++) begin
            if (page_busy[i]) begin
               page_busy[i] = 1'b0;
               if (free_shadow < bpa_pkg::COUNT_MAX) free_shadow++;
            end
         end
         g.success = 1'b1;
      end
      g.free_count = free_shadow[16:0];
      return g;
   endfunction

   // Offers one transaction and records its expectation when it is taken.
   task automatic offer_request(logic command, logic [16:0] count, logic [15:0] first,
                                bit typed, page_grant_type typed_grant);
      page_grant_type g;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.command = command;
      req_bus.page_count = count;
      req_bus.first_page = first;
      do @(posedge clock); while (!req_bus.ready);
      g = predict_page_op(command, count, first);
      expected_grants.push_back(typed ? typed_grant : g);
      @(negedge clock);
   endtask

   // The register is only written once the block has gone quiet.
   task automatic set_page_total(logic [16:0] value);
      req_bus.valid = 1'b0;
      wait (expected_grants.size() == 0);
      repeat (20) @(negedge clock);
      csr_write_en = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      total_shadow = {15'd0, value};
   endtask

   task automatic random_phase(int unsigned items);
      int unsigned win;
      logic [16:0] count;
      logic [15:0] first;
      logic command;
      page_grant_type none;
      none = '{1'b0, '0, '0};
      for (int n = 0; n < items; n++) begin
         win = (window_size() == 0) ? 1 : window_size();
         command = 1'($urandom_range(0, 1));
         if (command == bpa_pkg::CMD_ALLOC) begin
            case ($urandom_range(0, 19))
               0: count = '0;
               1, 2: count = 17'($urandom_range(1, 65536));
               default: count = 17'($urandom_range(1, (win > 8) ? win / 8 : 1));
            endcase
            first = 16'($urandom_range(0, 65535));
         end else begin
            if ($urandom_range(0, 149) == 0) count = 17'($urandom_range(1, 65536));
            else count = 17'($urandom_range(0, (win > 4) ? win / 4 : 2));
            if ($urandom_range(0, 9) == 0) first = 16'($urandom_range(0, 65535));
            else first = 16'($urandom_range(0, win - 1));
         end
         offer_request(command, count, first, 1'b0, none);
      end
   endtask

   always @(posedge clock) begin
      page_grant_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_grants.size() == 0) begin
            $display("%0t: unexpected transaction success=%0d run_start=%0d free_count=%0d",
                     $time, rsp_bus.success, rsp_bus.run_start, rsp_bus.free_count);
            mismatch_count++;
         end else begin
            e = expected_grants.pop_front();
            if (rsp_bus.success !== e.success) begin
               $display("%0t: success expected %0d actual %0d", $time, e.success,
                        rsp_bus.success);
               mismatch_count++;
            end
            if (rsp_bus.run_start !== e.run_start) begin
               $display("%0t: run_start expected %0d actual %0d", $time, e.run_start,
                        rsp_bus.run_start);
               mismatch_count++;
            end
            if (rsp_bus.free_count !== e.free_count) begin
               $display("%0t: free_count expected %0d actual %0d", $time, e.free_count,
                        rsp_bus.free_count);
               mismatch_count++;
            end
         end
      end
   end

   // Result side: random back-pressure plus one long hold-off on request.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_bus.ready = 1'b0;
            for (int c = 0; c < 400; c++) @(negedge clock);
            long_hold_req = 0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
      end
   end

   initial begin
      dir_row_type rows[$];
      page_grant_type g;
      int unsigned phase_total[6];
      int unsigned phase_items[6];

      phase_total = '{64, 1, 257, 1000, 65536, 300};
      phase_items = '{150, 60, 170, 190, 6, 150};
      for (int i = 0; i < bpa_pkg::MAX_PAGES; i++) page_busy[i] = 1'b1;
      cursor_shadow = 0;
      free_shadow = 0;
      total_shadow = 0;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.command = bpa_pkg::CMD_ALLOC;
      req_bus.page_count = '0;
      req_bus.first_page = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // An empty window: nothing can be allocated or freed.
      rows.push_back('{0, 0, bpa_pkg::CMD_ALLOC, 1, 0, 1, 0, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_FREE, 5, 0, 1, 1, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_ALLOC, 0, 0, 1, 0, 0, 0});
      // Register beyond the map size clamps to the full map.
      rows.push_back('{1, 131071, bpa_pkg::CMD_ALLOC, 0, 0, 0, 0, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_FREE, 1, 65535, 1, 1, 0, 1});
      rows.push_back('{0, 0, bpa_pkg::CMD_FREE, 0, 0, 1, 1, 0, 1});
      rows.push_back('{0, 0, bpa_pkg::CMD_ALLOC, 1, 0, 1, 1, 65535, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_ALLOC, 65536, 0, 1, 0, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_FREE, 65536, 0, 1, 1, 0, 65536});
      rows.push_back('{0, 0, bpa_pkg::CMD_ALLOC, 65536, 0, 1, 1, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_FREE, 65536, 65535, 1, 1, 0, 1});
      // Small window: next-fit, wrap, long runs, repeated and clipped frees.
      rows.push_back('{1, 100, bpa_pkg::CMD_ALLOC, 0, 0, 0, 0, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_FREE, 100, 0, 0, 0, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_ALLOC, 30, 0, 0, 0, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_ALLOC, 30, 0, 0, 0, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_ALLOC, 50, 0, 0, 0, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_FREE, 5, 10, 0, 0, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_ALLOC, 5, 0, 0, 0, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_ALLOC, 200, 0, 0, 0, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_FREE, 30, 90, 0, 0, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_FREE, 20, 40, 0, 0, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_ALLOC, 40, 0, 0, 0, 0, 0});
      rows.push_back('{0, 0, bpa_pkg::CMD_ALLOC, 1, 0, 0, 0, 0, 0});

      foreach (rows[i]) begin
         if (rows[i].is_cfg) begin
            set_page_total(rows[i].cfg_total);
         end else begin
            g = '{rows[i].success, rows[i].run_start, rows[i].free_count};
            offer_request(rows[i].command, rows[i].page_count, rows[i].first_page,
                          rows[i].typed, g);
         end
      end

      foreach (phase_total[p]) begin
         set_page_total(17'(phase_total[p]));
         if (p == 1) long_hold_req = 1;
         if (p == 5) quiet_phase = 1;
         random_phase(phase_items[p]);
      end

      req_bus.valid = 1'b0;
      wait (expected_grants.size() == 0);
      repeat (50) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
